// File: rtl/itoa_pkg.sv
package itoa_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int DIGIT_W    = 4;
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 5;
    localparam int CHAR_W     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_ALPHA = 8'h37;   // 'A' - 10
    localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;

    typedef struct packed {
        logic clear;
        logic load_bit;
        logic shift_up;
    } row_ctrl_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
            glyph = ASCII_ZERO + ext;
        else
            glyph = ASCII_ALPHA + ext;
    endfunction

endpackage

// File: rtl/itoa_in_if.sv
interface itoa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [itoa_pkg::VALUE_W-1:0] value;
    logic        [itoa_pkg::RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

// File: rtl/itoa_out_if.sv
interface itoa_out_if;
    logic                         valid;
    logic                         ready;
    logic [itoa_pkg::CHAR_W-1:0]  character;
    logic                         last;
    logic                         bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

// File: rtl/itoa_digit_row.sv
module itoa_digit_row (
    input  logic                                clk,
    input  logic                                rst_n,
    input  itoa_pkg::row_ctrl_t                 ctrl,
    input  logic                                bit_in,
    input  logic [itoa_pkg::RADIX_W-1:0]        radix,
    output logic [itoa_pkg::DIGIT_W-1:0]        top_digit,
    output logic [itoa_pkg::COUNT_W-1:0]        digit_count
);

    localparam int N = itoa_pkg::MAX_DIGITS;

    logic [itoa_pkg::DIGIT_W-1:0] cell_reg  [N];
    logic [itoa_pkg::DIGIT_W-1:0] cell_next [N];
    logic [itoa_pkg::COUNT_W-1:0] count_reg;
    logic [itoa_pkg::COUNT_W-1:0] count_next;

    logic [N-1:0] gen;
    logic [N-1:0] prop;
    logic [N:0]   sum;
    logic [N:0]   carry;

    // Each cell doubles its digit and adds the carry from below; a cell
    // generates a carry when 2d >= radix and passes one on when 2d == radix-1.
    always_comb
    begin
        logic [itoa_pkg::RADIX_W-1:0] dbl;
        logic [itoa_pkg::RADIX_W-1:0] t;
        logic [itoa_pkg::RADIX_W-1:0] diff;
        for (int i = 0; i < N; i++)
        begin
            dbl     = {cell_reg[i], 1'b0};
            gen[i]  = (dbl >= radix);
            prop[i] = (dbl == (radix - 5'd1));
        end
        sum = {1'b0, gen} + {1'b0, gen | prop} + {{N{1'b0}}, bit_in};
        carry[N] = sum[N];
        for (int i = 0; i < N; i++)
            carry[i] = sum[i] ^ gen[i] ^ (gen[i] | prop[i]);
        for (int i = 0; i < N; i++)
        begin
            t    = {cell_reg[i], carry[i]};
            diff = t - radix;
            if (t >= radix)
                cell_next[i] = diff[itoa_pkg::DIGIT_W-1:0];
            else
                cell_next[i] = t[itoa_pkg::DIGIT_W-1:0];
        end
        // a new top digit can only appear just above the current one
        count_next = count_reg + {{(itoa_pkg::COUNT_W-1){1'b0}}, carry[count_reg]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            for (int i = 0; i < N; i++)
                cell_reg[i] <= '0;
        end
        else if (ctrl.load_bit)
        begin
            for (int i = 0; i < N; i++)
                cell_reg[i] <= cell_next[i];
        end
        else if (ctrl.shift_up)
        begin
            for (int i = N - 1; i > 0; i--)
                cell_reg[i] <= cell_reg[i-1];
            cell_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.clear)
            count_reg <= '0;
        else if (ctrl.load_bit)
            count_reg <= count_next;
    end

    assign top_digit   = cell_reg[N-1];
    assign digit_count = count_reg;

endmodule

// File: rtl/integer_to_radix_ascii.sv
// Converts a signed 64-bit integer to ASCII digits in a base from 2 to 16.
// operand (sink): value, radix. result (source): character, last, bad_radix,
// one item per character, most significant digit first, last set on the
// final one. A negative value is converted by its magnitude; a '-' leads
// only in base 10. Zero gives "0". A radix outside 2..16 gives a single
// item with character 0, last 1 and bad_radix 1.
// One item is converted at a time; operand.ready is high only while idle.
// Conversion shifts the magnitude bit by bit into a row of radix-r digit
// cells (one carry chain across the row per cycle); readout then shifts
// the row out one digit a cycle while the result slot is free, leading
// zero cells dropped, after a '-' if the value is negative in base 10.
// A bad radix gives its item without a conversion.
// The result register holds its item while result.ready is low and the
// readout pauses until the slot frees; conversion is not affected.
// Reset clears the control state and the result valid; digit cells are
// cleared at the start of every conversion.
module integer_to_radix_ascii (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    operand,
    itoa_out_if.source result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    localparam logic [itoa_pkg::POS_W-1:0]   POS_LAST  = itoa_pkg::POS_W'(itoa_pkg::MAX_DIGITS - 1);
    localparam logic [itoa_pkg::COUNT_W-1:0] COUNT_ONE = itoa_pkg::COUNT_W'(1);
    localparam logic [itoa_pkg::COUNT_W-1:0] COUNT_TOP = itoa_pkg::COUNT_W'(itoa_pkg::MAX_DIGITS);

    logic [2:0] state_reg, state_next;
    logic [itoa_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [itoa_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic                         sign_reg, sign_next;
    logic [itoa_pkg::POS_W-1:0]   pos_reg, pos_next;

    logic                         out_valid_reg, out_valid_next;
    logic [itoa_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_bad_reg, out_bad_next;

    itoa_pkg::row_ctrl_t          row_ctrl;
    logic [itoa_pkg::DIGIT_W-1:0] top_digit;
    logic [itoa_pkg::COUNT_W-1:0] digit_count;
    logic [itoa_pkg::COUNT_W-1:0] ndig;
    logic                         slot_free;
    logic                         in_fire;
    logic                         radix_ok;
    logic                         neg;
    logic                         pos_live;

    itoa_digit_row u_row (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (row_ctrl),
        .bit_in      (mag_reg[itoa_pkg::VALUE_W-1]),
        .radix       (radix_reg),
        .top_digit   (top_digit),
        .digit_count (digit_count)
    );

    assign operand.ready = (state_reg == ST_IDLE);
    assign in_fire   = operand.valid && operand.ready;
    assign radix_ok  = operand.radix inside {[itoa_pkg::RADIX_MIN:itoa_pkg::RADIX_MAX]};
    assign neg       = operand.value[itoa_pkg::VALUE_W-1];
    assign slot_free = !out_valid_reg || result.ready;
    assign ndig      = (digit_count == '0) ? COUNT_ONE : digit_count;
    // top cell holds digit (63 - pos); it is a real digit once below ndig
    assign pos_live  = (({1'b0, pos_reg} + ndig) >= COUNT_TOP);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        radix_next     = radix_reg;
        sign_next      = sign_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        row_ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (radix_ok)
                    begin
                        mag_next     = neg ? (~operand.value + 64'd1) : operand.value;
                        radix_next   = operand.radix;
                        sign_next    = neg && (operand.radix == itoa_pkg::RADIX_DEC);
                        pos_next     = '0;
                        row_ctrl.clear = 1'b1;
                        state_next   = ST_CONV;
                    end
                    else
                        state_next = ST_BAD;
                end
            end
            ST_CONV:
            begin
                row_ctrl.load_bit = 1'b1;
                mag_next = {mag_reg[itoa_pkg::VALUE_W-2:0], 1'b0};
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_LAST)
                    state_next = sign_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::ASCII_MINUS;
                    out_last_next  = 1'b0;
                    out_bad_next   = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // drop leading zero cells without using the result slot
                if (!pos_live || slot_free)
                begin
                    row_ctrl.shift_up = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (pos_live)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = itoa_pkg::glyph(top_digit);
                        out_last_next  = (pos_reg == POS_LAST);
                        out_bad_next   = 1'b0;
                    end
                    if (pos_reg == POS_LAST)
                        state_next = ST_IDLE;
                end
            end
            ST_BAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::ASCII_NUL;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sign_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            sign_reg      <= sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        radix_reg    <= radix_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.character = out_char_reg;
    assign result.last      = out_last_reg;
    assign result.bad_radix = out_bad_reg;

    a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_last_reg && out_char_reg == itoa_pkg::ASCII_NUL))
        else $error("bad radix item must be a lone NUL with last set");

    a_emit_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> (out_valid_reg && out_last_reg))
        else $error("conversion ended without a last character");

    a_sign_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> (sign_reg && radix_reg == itoa_pkg::RADIX_DEC))
        else $error("sign emitted outside base ten");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (digit_count <= COUNT_TOP))
        else $error("digit count beyond row length");

endmodule
